// ===== sv/b64enc_pkg.sv =====
`timescale 1ns / 1ps

package b64enc_pkg;

   localparam logic [6:0] PAD_CHAR = 7'd61;
   localparam int unsigned CHARS_PER_JOB = 4;

   // Group position: bytes already taken in the current three-byte group.
   typedef enum logic [1:0] {
      PHASE_0     = 2'd0,
      PHASE_1     = 2'd1,
      PHASE_2     = 2'd2,
      PHASE_UNUSED = 2'd3
   } phase_type;

   // One encoded byte: up to four characters, emitted index 0 first.
   typedef struct packed {
      logic [CHARS_PER_JOB-1:0][6:0] chars;
      logic [1:0]                    last_idx;
      logic                          last;
   } job_type;

   // Front status seen by the top level.
   typedef struct packed {
      phase_type phase;
      logic [3:0] carry;
   } front_status_type;

   // Sextet value to base64 ASCII code.
   function automatic logic [6:0] sextet_to_ascii(input logic [5:0] sextet);
      logic [6:0] v;
      logic [6:0] code;
      v = {1'b0, sextet};
      if (sextet < 6'd26) begin
         code = 7'd65 + v;
      end else if (sextet < 6'd52) begin
         code = 7'd97 + (v - 7'd26);
      end else if (sextet < 6'd62) begin
         code = 7'd48 + (v - 7'd52);
      end else if (sextet == 6'd62) begin
         code = 7'd43;
      end else begin
         code = 7'd47;
      end
      return code;
   endfunction

endpackage

// ===== sv/b64enc_front.sv =====
`timescale 1ns / 1ps

module b64enc_front (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          accept,
   input  logic [7:0]                    data_byte,
   input  logic                          last_byte,
   output b64enc_pkg::job_type           job,
   output b64enc_pkg::front_status_type  status
);

   b64enc_pkg::phase_type phase_ff, phase_in, phase_cur;
   logic [3:0]            carry_ff, carry_in;

   always_comb begin
      phase_cur = (phase_ff == b64enc_pkg::PHASE_UNUSED) ? b64enc_pkg::PHASE_0 : phase_ff;
      job       = '0;
      phase_in  = phase_ff;
      carry_in  = carry_ff;
      job.last  = last_byte;
      job.chars[2] = b64enc_pkg::PAD_CHAR;
      job.chars[3] = b64enc_pkg::PAD_CHAR;
      unique case (phase_cur)
         b64enc_pkg::PHASE_1: begin
            job.chars[0] = b64enc_pkg::sextet_to_ascii({carry_ff[1:0], data_byte[7:4]});
            job.chars[1] = b64enc_pkg::sextet_to_ascii({data_byte[3:0], 2'b00});
            job.last_idx = last_byte ? 2'd2 : 2'd0;
            carry_in     = data_byte[3:0];
            phase_in     = b64enc_pkg::PHASE_2;
         end
         b64enc_pkg::PHASE_2: begin
            job.chars[0] = b64enc_pkg::sextet_to_ascii({carry_ff, data_byte[7:6]});
            job.chars[1] = b64enc_pkg::sextet_to_ascii(data_byte[5:0]);
            job.last_idx = 2'd1;
            carry_in     = 4'd0;
            phase_in     = b64enc_pkg::PHASE_0;
         end
         default: begin
            job.chars[0] = b64enc_pkg::sextet_to_ascii(data_byte[7:2]);
            job.chars[1] = b64enc_pkg::sextet_to_ascii({data_byte[1:0], 4'b0000});
            job.last_idx = last_byte ? 2'd3 : 2'd0;
            carry_in     = {2'b00, data_byte[1:0]};
            phase_in     = b64enc_pkg::PHASE_1;
         end
      endcase
      // final byte closes the message
      if (last_byte) begin
         phase_in = b64enc_pkg::PHASE_0;
         carry_in = 4'd0;
      end
      status.phase = phase_ff;
      status.carry = carry_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= b64enc_pkg::PHASE_0;
         carry_ff <= 4'd0;
      end else if (accept) begin
         phase_ff <= phase_in;
         carry_ff <= carry_in;
      end
   end

endmodule

// ===== sv/b64enc_queue.sv =====
`timescale 1ns / 1ps

module b64enc_queue #(
   parameter int unsigned DEPTH = 2
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                push_valid,
   output logic                push_ready,
   input  b64enc_pkg::job_type push_job,
   output logic                pop_valid,
   input  logic                pop_ready,
   output b64enc_pkg::job_type pop_job
);

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

   b64enc_pkg::job_type slots_ff [DEPTH];
   logic [PTR_W-1:0]    wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0]    count_ff;
   logic                push, pop;

   assign push_ready = (count_ff != FULL_CNT);
   assign pop_valid  = (count_ff != '0);
   assign pop_job    = slots_ff[rd_ptr_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   always_ff @(posedge clock) begin
      if (push) begin
         slots_ff[wr_ptr_ff] <= push_job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
         end
         if (push && !pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (pop && !push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

endmodule

// ===== sv/b64enc_back.sv =====
`timescale 1ns / 1ps

module b64enc_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                job_valid,
   output logic                job_ready,
   input  b64enc_pkg::job_type job,
   output logic                out_valid,
   input  logic                out_ready,
   output logic [6:0]          out_char,
   output logic                out_last
);

   b64enc_pkg::job_type cur_ff;
   logic                cur_valid_ff, cur_valid_in;
   logic [1:0]          idx_ff, idx_in;
   logic                out_valid_ff, out_valid_in;
   logic [6:0]          out_char_ff, out_char_in;
   logic                out_last_ff, out_last_in;
   logic                out_free, emit, job_done;

   always_comb begin
      out_free     = !out_valid_ff || out_ready;
      emit         = out_free && cur_valid_ff;
      job_done     = emit && (idx_ff == cur_ff.last_idx);
      job_ready    = !cur_valid_ff || job_done;
      cur_valid_in = cur_valid_ff;
      idx_in       = idx_ff;
      out_valid_in = out_valid_ff && !out_ready;
      out_char_in  = out_char_ff;
      out_last_in  = out_last_ff;
      if (emit) begin
         out_valid_in = 1'b1;
         out_char_in  = cur_ff.chars[idx_ff];
         out_last_in  = cur_ff.last && (idx_ff == cur_ff.last_idx);
         idx_in       = idx_ff + 1'b1;
      end
      if (job_ready) begin
         cur_valid_in = job_valid;
         idx_in       = 2'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_valid_ff <= 1'b0;
         idx_ff       <= 2'd0;
         out_valid_ff <= 1'b0;
      end else begin
         cur_valid_ff <= cur_valid_in;
         idx_ff       <= idx_in;
         out_valid_ff <= out_valid_in;
      end
      if (job_ready && job_valid) begin
         cur_ff <= job;
      end
      out_char_ff <= out_char_in;
      out_last_ff <= out_last_in;
   end

   assign out_valid = out_valid_ff;
   assign out_char  = out_char_ff;
   assign out_last  = out_last_ff;

endmodule

// ===== sv/base64_stream_encoder.sv =====
`timescale 1ns / 1ps

// Base64 (RFC 4648) stream encoder, alphabet A-Z a-z 0-9 + / with '=' pad.
// Request channel: one raw byte per item (req_data_byte) plus req_last_byte
// on the final byte of a message. Response channel: one ASCII character per
// item (rsp_char_code), rsp_last_char set on the final character.
// Each byte yields 1 or 2 characters mid-message; the last byte flushes the
// group and pads, for 2, 3 or 4 characters in total.
// Throughput is one character per cycle while rsp_ready stays high, set by
// the single output register: a byte yields 1 to 4 characters, about 4/3
// characters per byte on a long message. After a byte is accepted, its job
// passes a queue slot, the back-end job register and the output register.
// The front classifies bytes into character jobs; a QUEUE_DEPTH-entry job
// queue separates it from the back end, which streams characters out.
// req_ready drops only when the queue is full, so bytes keep coming in while
// characters wait at the output. A stalled rsp_ready holds the current
// character; the back end and then the queue fill up behind it.
// Reset (synchronous, active high) empties the queue and output register
// and returns the encoder to the start of a group.

module base64_stream_encoder #(
   parameter int unsigned QUEUE_DEPTH = 2
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_data_byte,
   input  logic       req_last_byte,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [6:0] rsp_char_code,
   output logic       rsp_last_char
);

   b64enc_pkg::job_type          push_job, pop_job;
   b64enc_pkg::front_status_type front_status;
   logic                         req_accept;
   logic                         pop_valid, pop_ready;

   assign req_accept = req_valid && req_ready;

   // Front: tracks group phase and carried bits, builds a job per byte.
   b64enc_front u_front (
      .clock     (clock),
      .reset     (reset),
      .accept    (req_accept),
      .data_byte (req_data_byte),
      .last_byte (req_last_byte),
      .job       (push_job),
      .status    (front_status)
   );

   // Job queue between front and back end.
   b64enc_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (req_valid),
      .push_ready (req_ready),
      .push_job   (push_job),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_job    (pop_job)
   );

   // Back end: one character per cycle into the output register while rsp_ready is high.
   b64enc_back u_back (
      .clock     (clock),
      .reset     (reset),
      .job_valid (pop_valid),
      .job_ready (pop_ready),
      .job       (pop_job),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_char  (rsp_char_code),
      .out_last  (rsp_last_char)
   );

   // Group phase never reaches the unused code.
   assert property (@(posedge clock) disable iff (reset)
      front_status.phase != b64enc_pkg::PHASE_UNUSED)
      else $error("group phase reached unused code");

   // A final byte returns the front to the start of a clean group.
   assert property (@(posedge clock) disable iff (reset)
      (req_accept && req_last_byte) |=>
         (front_status.phase == b64enc_pkg::PHASE_0 && front_status.carry == 4'd0))
      else $error("front not cleared after final byte");

   // A mid-message byte at group start moves to phase one with two carried bits.
   assert property (@(posedge clock) disable iff (reset)
      (req_accept && !req_last_byte && front_status.phase == b64enc_pkg::PHASE_0) |=>
         (front_status.phase == b64enc_pkg::PHASE_1 && front_status.carry[3:2] == 2'b00))
      else $error("phase advance from group start wrong");

endmodule

// ===== test/base64_stream_encoder_checker.sv =====
`timescale 1ns / 1ps

module base64_stream_encoder_checker (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       req_ready,
   input  logic [7:0] req_data_byte,
   input  logic       req_last_byte,
   input  logic       rsp_valid,
   input  logic       rsp_ready,
   input  logic [6:0] rsp_char_code,
   input  logic       rsp_last_char,
   output int         fail_count,
   output int         chars_pending
);

   // sextet s sits at bits (63-s)*8 +: 8
   localparam logic [511:0] ALPHABET =
      "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

   typedef struct {
      logic [6:0] code;
      logic       last;
   } encoded_char_type;

   encoded_char_type      expected_chars[$];
   b64enc_pkg::phase_type group_phase = b64enc_pkg::PHASE_0;
   logic [3:0]            carry_bits = 4'd0;
   int                    mismatches = 0;
   int                    queued = 0;

   assign fail_count = mismatches;
   assign chars_pending = queued;

   task automatic report_mismatch(input string what, input int want, input int got);
      $display("mismatch at %0t: %s, expected %0d, got %0d", $time, what, want, got);
      mismatches++;
   endtask

   task automatic push_code(input logic [6:0] code);
      encoded_char_type c;
      c.code = code;
      c.last = 1'b0;
      expected_chars.push_back(c);
   endtask

   task automatic push_sextet(input logic [5:0] s);
      push_code(ALPHABET[(63 - int'(s)) * 8 +: 7]);
   endtask

   // characters completed by one byte; flush and pad on the last byte
   task automatic encode_byte(input logic [7:0] b, input logic last);
      b64enc_pkg::phase_type ph;
      encoded_char_type      tail;
      ph = group_phase;
      if (ph == b64enc_pkg::PHASE_UNUSED) ph = b64enc_pkg::PHASE_0;
      case (ph)
         b64enc_pkg::PHASE_0: begin
            push_sextet(b[7:2]);
            carry_bits = {2'b00, b[1:0]};
            group_phase = b64enc_pkg::PHASE_1;
            if (last) begin
               push_sextet({carry_bits[1:0], 4'b0000});
               push_code(b64enc_pkg::PAD_CHAR);
               push_code(b64enc_pkg::PAD_CHAR);
            end
         end
         b64enc_pkg::PHASE_1: begin
            push_sextet({carry_bits[1:0], b[7:4]});
            carry_bits = b[3:0];
            group_phase = b64enc_pkg::PHASE_2;
            if (last) begin
               push_sextet({carry_bits, 2'b00});
               push_code(b64enc_pkg::PAD_CHAR);
            end
         end
         default: begin
            push_sextet({carry_bits, b[7:6]});
            push_sextet(b[5:0]);
            carry_bits = 4'd0;
            group_phase = b64enc_pkg::PHASE_0;
         end
      endcase
      if (last) begin
         tail = expected_chars.pop_back();
         tail.last = 1'b1;
         expected_chars.push_back(tail);
         group_phase = b64enc_pkg::PHASE_0;
         carry_bits = 4'd0;
      end
   endtask

   always @(posedge clock) begin
      encoded_char_type want;
      if (reset) begin
         expected_chars.delete();
         group_phase = b64enc_pkg::PHASE_0;
         carry_bits = 4'd0;
      end else begin
         // compare before predicting: a byte never yields a char in its own cycle
         if (rsp_valid && rsp_ready) begin
            if (expected_chars.size() == 0) begin
               report_mismatch("character with none expected", -1, rsp_char_code);
            end else begin
               want = expected_chars.pop_front();
               if (rsp_char_code !== want.code)
                  report_mismatch("char_code", want.code, rsp_char_code);
               if (rsp_last_char !== want.last)
                  report_mismatch("last_char", want.last, rsp_last_char);
            end
         end
         if (req_valid && req_ready) encode_byte(req_data_byte, req_last_byte);
      end
      queued = expected_chars.size();
   end

endmodule

// ===== test/base64_stream_encoder_test.sv =====
`timescale 1ns / 1ps

module base64_stream_encoder_test;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_ready;
   logic [7:0] req_data_byte = 8'd0;
   logic       req_last_byte = 1'b0;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   logic [6:0] rsp_char_code;
   logic       rsp_last_char;

   int fail_count;
   int chars_pending;

   // steady: no idling on either side; output_hold: ask the receiver for a long stall
   bit steady = 1'b0;
   bit output_hold = 1'b0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   base64_stream_encoder dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_data_byte (req_data_byte),
      .req_last_byte (req_last_byte),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_char_code (rsp_char_code),
      .rsp_last_char (rsp_last_char)
   );

   base64_stream_encoder_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_data_byte (req_data_byte),
      .req_last_byte (req_last_byte),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_char_code (rsp_char_code),
      .rsp_last_char (rsp_last_char),
      .fail_count    (fail_count),
      .chars_pending (chars_pending)
   );

   // Offer one byte. Called at a falling edge; returns at the falling edge
   // after the item is taken, so valid stays high straight into the next item
   // unless a random gap drops it first.
   task automatic send_byte(input logic [7:0] b, input logic last);
      if (!steady) begin
         while ($urandom_range(99) < 15) begin
            req_valid <= 1'b0;
            @(negedge clock);
         end
      end
      req_valid <= 1'b1;
      req_data_byte <= b;
      req_last_byte <= last;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
   endtask

   // Random message: mostly short so every group phase ends a message often.
   task automatic send_message(input int len);
      for (int i = 0; i < len; i++) send_byte(8'($urandom_range(255)), i == len - 1);
   endtask

   // Receiver: ready drops about 15 percent of the time, never while steady.
   // On request it stalls so that the job queue fills and req_ready falls.
   initial begin
      forever begin
         @(negedge clock);
         if (output_hold) begin
            output_hold = 1'b0;
            rsp_ready <= 1'b0;
            repeat (60) @(negedge clock);
         end
         rsp_ready <= steady || ($urandom_range(99) >= 15);
      end
   end

   initial begin
      int sent;
      int msgs;
      int len;
      sent = 0;
      msgs = 0;

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // one-byte messages at both extremes: flush from the start of a group
      send_byte(8'h00, 1'b1);
      send_byte(8'hFF, 1'b1);
      // two bytes: flush after the second byte, single pad
      send_byte(8'hFF, 1'b0);
      send_byte(8'h00, 1'b1);
      // three bytes: last byte closes the group, no pad
      send_byte(8'h00, 1'b0);
      send_byte(8'hFF, 1'b0);
      send_byte(8'hFC, 1'b1);
      // '+' and '/' twice, then a full group ending the message
      send_byte(8'hFB, 1'b0);
      send_byte(8'hFF, 1'b0);
      send_byte(8'hBF, 1'b0);
      send_byte(8'h4D, 1'b0);
      send_byte(8'h61, 1'b0);
      send_byte(8'h6E, 1'b1);
      // alternating bits, then a byte starting a new group as the last one
      send_byte(8'hAA, 1'b0);
      send_byte(8'h55, 1'b0);
      send_byte(8'h80, 1'b0);
      send_byte(8'h01, 1'b1);
      // next message right after a final byte: state must be back at zero
      send_byte(8'h7F, 1'b0);
      send_byte(8'hFE, 1'b1);

      // 19 directed bytes above, the rest random
      while (sent < 91) begin
         if (msgs == 4) output_hold = 1'b1;
         if (msgs == 8) begin
            // sender pause: let every char drain before going on
            req_valid <= 1'b0;
            wait (chars_pending == 0);
            @(negedge clock);
         end
         steady = (msgs >= 10 && msgs < 15);
         len = ($urandom_range(9) == 0) ? $urandom_range(10, 16) : $urandom_range(1, 7);
         send_message(len);
         sent += len;
         msgs++;
      end
      req_valid <= 1'b0;
      steady = 1'b0;

      wait (chars_pending == 0);
      // room for any stray char beyond the last expected one
      repeat (10) @(posedge clock);
      if (fail_count == 0) begin
         $display("base64_stream_encoder verification clean");
      end else begin
         $display("base64_stream_encoder verification failed");
      end
      $finish;
   end

   initial begin
      #2000000;
      $display("base64_stream_encoder verification failed");
      $finish;
   end

endmodule
